// ===== hdl/lcg_pkg.sv =====
`timescale 1ns / 1ps

package lcg_pkg;

   // Verdict codes carried on rsp_verdict
   localparam logic [2:0] VERD_OK        = 3'd0;
   localparam logic [2:0] VERD_BLACK     = 3'd1;
   localparam logic [2:0] VERD_SAME      = 3'd2;
   localparam logic [2:0] VERD_SCORE     = 3'd3;
   localparam logic [2:0] VERD_AMBIGUOUS = 3'd4;
   localparam logic [2:0] VERD_GEOMETRY  = 3'd5;
   localparam logic [2:0] VERD_FIT       = 3'd6;
   localparam logic [2:0] VERD_CORRECT   = 3'd7;

   // CSR indexes
   localparam logic [2:0] CSR_REJECT_LIMIT    = 3'd0;
   localparam logic [2:0] CSR_BLACKLIST_TICKS = 3'd1;
   localparam logic [2:0] CSR_MAX_MATCH       = 3'd2;
   localparam logic [2:0] CSR_MIN_MARGIN      = 3'd3;
   localparam logic [2:0] CSR_MAX_FIT         = 3'd4;
   localparam logic [2:0] CSR_MAX_SHIFT       = 3'd5;
   localparam logic [2:0] CSR_MAX_TURN        = 3'd6;

   // CSR reset values
   localparam logic [7:0]         RST_REJECT_LIMIT    = 8'd3;
   localparam logic [31:0]        RST_BLACKLIST_TICKS = 32'd30000;
   localparam logic signed [15:0] RST_MAX_MATCH       = 16'sd256;
   localparam logic signed [15:0] RST_MIN_MARGIN      = 16'sd32;
   localparam logic signed [15:0] RST_MAX_FIT         = 16'sd128;
   localparam logic [15:0]        RST_MAX_SHIFT       = 16'd5000;
   localparam logic [15:0]        RST_MAX_TURN        = 16'd3000;

   localparam logic [7:0] REJECT_SAT = 8'hFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Steps of the shared compare unit, in check order
   typedef enum logic [2:0] {
      CHK_SCORE,
      CHK_MARGIN,
      CHK_GEOM,
      CHK_FIT,
      CHK_SHIFT,
      CHK_TURN
   } chk_step_type;

endpackage

// ===== hdl/loop_candidate_gate.sv =====
`timescale 1ns / 1ps
// A new word is taken only in the idle state, after the previous word has gone through its update.
// The scan of the pair table runs one entry per cycle through its single read port;
//   the six checks overlap the scan.
// The result sits in an output register; the table update waits only if it is still held.
// Reset (synchronous, active high) clears the state machine, the entry-used bits and
//   restores the CSR defaults; table contents are not cleared and need no sweep.
module loop_candidate_gate
   import lcg_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int ID_BITS       = 16
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_first_frame,
   input  logic [15:0]        req_second_frame,
   input  logic signed [15:0] req_match_score,
   input  logic signed [15:0] req_runner_up_score,
   input  logic               req_geometry_ok,
   input  logic signed [15:0] req_fit_score,
   input  logic [15:0]        req_shift_mm,
   input  logic [15:0]        req_turn_cdeg,
   input  logic [31:0]        req_now_ticks,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accepted,
   output logic [2:0]         rsp_verdict,
   output logic               rsp_untracked,

   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   // CSRs
   logic [7:0]         reject_limit_ff;
   logic [31:0]        blacklist_ticks_ff;
   logic signed [15:0] max_match_ff;
   logic signed [15:0] min_margin_ff;
   logic signed [15:0] max_fit_ff;
   logic [15:0]        max_shift_ff;
   logic [15:0]        max_turn_ff;

   // Pair table: used bits in flops, the rest in a memory
   logic                 entry_used_ff  [TABLE_ENTRIES];
   logic [ID_BITS-1:0]   entry_low_ff   [TABLE_ENTRIES];
   logic [ID_BITS-1:0]   entry_high_ff  [TABLE_ENTRIES];
   logic [7:0]           entry_rej_ff   [TABLE_ENTRIES];
   logic [31:0]          entry_exp_ff   [TABLE_ENTRIES];

   // Captured word
   logic [ID_BITS-1:0]   lo_id_ff, lo_id_in;
   logic [ID_BITS-1:0]   hi_id_ff, hi_id_in;
   logic signed [15:0]   match_ff;
   logic signed [15:0]   runner_ff;
   logic                 geom_ff;
   logic signed [15:0]   fit_ff;
   logic [15:0]          shift_ff;
   logic [15:0]          turn_ff;
   logic [31:0]          now_ff;

   // Sequencer
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     scan_idx_ff;
   logic                 issue_done_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 rd_used_ff;
   logic [ID_BITS-1:0]   rd_low_ff;
   logic [ID_BITS-1:0]   rd_high_ff;
   logic [7:0]           rd_rej_ff;
   logic [31:0]          rd_exp_ff;

   logic                 hit_ff;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic [7:0]           hit_rej_ff;
   logic [31:0]          hit_exp_ff;
   logic                 free_ff;
   logic [IDX_W-1:0]     free_idx_ff;

   chk_step_type         chk_step_ff, chk_step_in;
   logic                 chk_done_ff;
   logic [2:0]           verdict_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_accepted_ff;
   logic [2:0]           rsp_verdict_ff;
   logic                 rsp_untracked_ff;

   // Control decode
   logic                 req_take;
   logic                 scan_issue;
   logic                 chk_en;
   logic                 upd_go;
   logic                 scan_end;

   // Shared compare unit
   logic signed [17:0]   cmp_a;
   logic signed [17:0]   cmp_b;
   logic [2:0]           cmp_code;
   logic                 cmp_gt;
   logic signed [16:0]   margin_diff;

   // Update datapath
   logic                 blacklisted;
   logic [2:0]           final_verdict;
   logic                 reject_rec;
   logic                 untracked;
   logic [IDX_W-1:0]     slot;
   logic [7:0]           rej_base;
   logic [7:0]           rej_new;
   logic [32:0]          exp_sum;
   logic [31:0]          exp_sat;
   logic [31:0]          exp_wr;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reject_limit_ff    <= RST_REJECT_LIMIT;
         blacklist_ticks_ff <= RST_BLACKLIST_TICKS;
         max_match_ff       <= RST_MAX_MATCH;
         min_margin_ff      <= RST_MIN_MARGIN;
         max_fit_ff         <= RST_MAX_FIT;
         max_shift_ff       <= RST_MAX_SHIFT;
         max_turn_ff        <= RST_MAX_TURN;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REJECT_LIMIT:    reject_limit_ff    <= csr_wdata[7:0];
            CSR_BLACKLIST_TICKS: blacklist_ticks_ff <= csr_wdata;
            CSR_MAX_MATCH:       max_match_ff       <= signed'(csr_wdata[15:0]);
            CSR_MIN_MARGIN:      min_margin_ff      <= signed'(csr_wdata[15:0]);
            CSR_MAX_FIT:         max_fit_ff         <= signed'(csr_wdata[15:0]);
            CSR_MAX_SHIFT:       max_shift_ff       <= csr_wdata[15:0];
            CSR_MAX_TURN:        max_turn_ff        <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (scan_end && chk_done_ff) state_in = ST_UPDATE;
         ST_UPDATE: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall  = 1'b1;
      scan_issue = 1'b0;
      chk_en     = 1'b0;
      upd_go     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SCAN: begin
            scan_issue = !issue_done_ff;
            chk_en     = !chk_done_ff;
         end
         ST_UPDATE: upd_go = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign req_take = req_valid && !req_stall;
   assign scan_end = issue_done_ff && !rd_vld_ff;

   // Unordered pair
   always_comb begin
      logic [ID_BITS-1:0] id_a;
      logic [ID_BITS-1:0] id_b;
      id_a = ID_BITS'(req_first_frame);
      id_b = ID_BITS'(req_second_frame);
      if (id_a < id_b) begin
         lo_id_in = id_a;
         hi_id_in = id_b;
      end else begin
         lo_id_in = id_b;
         hi_id_in = id_a;
      end
   end

   // Capture the word
   always_ff @(posedge clock) begin
      if (req_take) begin
         lo_id_ff  <= lo_id_in;
         hi_id_ff  <= hi_id_in;
         match_ff  <= req_match_score;
         runner_ff <= req_runner_up_score;
         geom_ff   <= req_geometry_ok;
         fit_ff    <= req_fit_score;
         shift_ff  <= req_shift_mm;
         turn_ff   <= req_turn_cdeg;
         now_ff    <= req_now_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Shared compare: one signed 18-bit greater-than per check step
   assign margin_diff = {runner_ff[15], runner_ff} - {match_ff[15], match_ff};

   always_comb begin
      cmp_a       = '0;
      cmp_b       = '0;
      cmp_code    = VERD_OK;
      chk_step_in = chk_step_ff;
      case (chk_step_ff)
         CHK_SCORE: begin
            cmp_a       = {{2{match_ff[15]}}, match_ff};
            cmp_b       = {{2{max_match_ff[15]}}, max_match_ff};
            cmp_code    = VERD_SCORE;
            chk_step_in = CHK_MARGIN;
         end
         CHK_MARGIN: begin
            cmp_a       = {{2{min_margin_ff[15]}}, min_margin_ff};
            cmp_b       = {margin_diff[16], margin_diff};
            cmp_code    = VERD_AMBIGUOUS;
            chk_step_in = CHK_GEOM;
         end
         CHK_GEOM: begin
            // 1 > geometry_ok exactly when registration failed
            cmp_a       = 18'sd1;
            cmp_b       = {17'd0, geom_ff};
            cmp_code    = VERD_GEOMETRY;
            chk_step_in = CHK_FIT;
         end
         CHK_FIT: begin
            cmp_a       = {{2{fit_ff[15]}}, fit_ff};
            cmp_b       = {{2{max_fit_ff[15]}}, max_fit_ff};
            cmp_code    = VERD_FIT;
            chk_step_in = CHK_SHIFT;
         end
         CHK_SHIFT: begin
            cmp_a       = {2'b00, shift_ff};
            cmp_b       = {2'b00, max_shift_ff};
            cmp_code    = VERD_CORRECT;
            chk_step_in = CHK_TURN;
         end
         CHK_TURN: begin
            cmp_a       = {2'b00, turn_ff};
            cmp_b       = {2'b00, max_turn_ff};
            cmp_code    = VERD_CORRECT;
            chk_step_in = CHK_TURN;
         end
         default: ;
      endcase
   end

   assign cmp_gt = cmp_a > cmp_b;

   // Check sequencer; first failure wins, same-frame set at capture
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_step_ff <= CHK_SCORE;
         chk_done_ff <= 1'b0;
      end else if (req_take) begin
         chk_step_ff <= CHK_SCORE;
         chk_done_ff <= 1'b0;
      end else if (chk_en) begin
         chk_step_ff <= chk_step_in;
         chk_done_ff <= (chk_step_ff == CHK_TURN);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         verdict_ff <= (lo_id_in == hi_id_in) ? VERD_SAME : VERD_OK;
      end else if (chk_en && cmp_gt && verdict_ff == VERD_OK) begin
         verdict_ff <= cmp_code;
      end
   end

   // Scan issue and read-valid tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         issue_done_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         rd_vld_ff <= scan_issue;
         if (req_take) begin
            scan_idx_ff   <= '0;
            issue_done_ff <= 1'b0;
         end else if (scan_issue) begin
            scan_idx_ff   <= scan_idx_ff + IDX_W'(1);
            issue_done_ff <= (scan_idx_ff == IDX_LAST);
         end
      end
   end

   // Table memory: registered read on the scan, one write in update
   always_ff @(posedge clock) begin
      if (scan_issue) begin
         rd_idx_ff  <= scan_idx_ff;
         rd_used_ff <= entry_used_ff[scan_idx_ff];
         rd_low_ff  <= entry_low_ff[scan_idx_ff];
         rd_high_ff <= entry_high_ff[scan_idx_ff];
         rd_rej_ff  <= entry_rej_ff[scan_idx_ff];
         rd_exp_ff  <= entry_exp_ff[scan_idx_ff];
      end
      if (upd_go && reject_rec) begin
         entry_low_ff[slot]  <= lo_id_ff;
         entry_high_ff[slot] <= hi_id_ff;
         entry_rej_ff[slot]  <= rej_new;
         entry_exp_ff[slot]  <= exp_wr;
      end
   end

   // Match and free-slot search on the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (req_take) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (rd_used_ff && rd_low_ff == lo_id_ff && rd_high_ff == hi_id_ff) begin
            hit_ff <= 1'b1;
         end
         if (!rd_used_ff && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff && rd_used_ff && rd_low_ff == lo_id_ff && rd_high_ff == hi_id_ff) begin
         hit_idx_ff <= rd_idx_ff;
         hit_rej_ff <= rd_rej_ff;
         hit_exp_ff <= rd_exp_ff;
      end
      if (rd_vld_ff && !rd_used_ff && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // Update datapath
   assign blacklisted   = hit_ff && (now_ff < hit_exp_ff);
   assign final_verdict = blacklisted ? VERD_BLACK : verdict_ff;
   assign reject_rec    = !blacklisted && verdict_ff != VERD_OK && (hit_ff || free_ff);
   assign untracked     = !blacklisted && verdict_ff != VERD_OK && !hit_ff && !free_ff;
   assign slot          = hit_ff ? hit_idx_ff : free_idx_ff;
   assign rej_base      = hit_ff ? hit_rej_ff : 8'd0;
   assign rej_new       = (rej_base == REJECT_SAT) ? REJECT_SAT : rej_base + 8'd1;
   assign exp_sum       = {1'b0, now_ff} + {1'b0, blacklist_ticks_ff};
   assign exp_sat       = exp_sum[32] ? '1 : exp_sum[31:0];

   always_comb begin
      if (rej_new >= reject_limit_ff) begin
         exp_wr = exp_sat;
      end else if (hit_ff) begin
         exp_wr = hit_exp_ff;
      end else begin
         exp_wr = '0;
      end
   end

   // Entry-used bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_used_ff[i] <= 1'b0;
         end
      end else if (upd_go) begin
         if (!blacklisted && verdict_ff == VERD_OK && hit_ff) begin
            entry_used_ff[hit_idx_ff] <= 1'b0;
         end else if (reject_rec && !hit_ff) begin
            entry_used_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go) begin
         rsp_accepted_ff  <= (final_verdict == VERD_OK);
         rsp_verdict_ff   <= final_verdict;
         rsp_untracked_ff <= untracked;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_untracked = rsp_untracked_ff;

endmodule

// ===== hdl/lcg_checker.sv =====
`timescale 1ns / 1ps

module lcg_checker
   import lcg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_accepted,
   input logic [2:0]  rsp_verdict,
   input logic        rsp_untracked
);

   // A held result word stays up
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // Accept flag agrees with the verdict code
   acc_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_verdict == VERD_OK)))
      else $error("rsp_accepted disagrees with rsp_verdict");

   // Only a rejection other than a blacklist refusal can be untracked
   untrk_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_untracked |-> (rsp_verdict != VERD_OK && rsp_verdict != VERD_BLACK))
      else $error("untracked flag on an accept or blacklist refusal");

   // Block is busy right after taking a word
   busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while a word is in work");

endmodule

bind loop_candidate_gate lcg_checker u_lcg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_accepted  (rsp_accepted),
   .rsp_verdict   (rsp_verdict),
   .rsp_untracked (rsp_untracked)
);
